### hdl/dfam_pkg.sv
// shared types, constants and helpers of the decimal float arithmetic unit
`timescale 1ns / 1ps

package dfam_pkg;

   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_MUL = 2'd1;
   localparam logic [1:0] OP_DIV = 2'd2;

   localparam logic [63:0] MANT_LIMIT = 64'((32'hffffffff) >> 1);

   localparam logic [6:0] DIV_SLOW_CYCLES = 7'd64;
   localparam logic [6:0] DIV_FAST_CYCLES = 7'd8;
   localparam logic [4:0] TEN = 5'd10;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_MUL,
      ST_SCALE,
      ST_DIV,
      ST_DWAIT,
      ST_ALIGN,
      ST_AWAIT,
      ST_NORM,
      ST_NWAIT,
      ST_FIN
   } dfam_state_type;

   typedef struct packed {
      logic start;
      logic fast;
   } dfam_div_req_type;

   // digit count of the divisor capped at 8, 1 for anything below ten
   function automatic logic [3:0] scale_digits(input logic signed [31:0] n);
      logic [3:0] k;
      k = 4'd1;
      if (n >= 32'sd10) k = k + 4'd1;
      if (n >= 32'sd100) k = k + 4'd1;
      if (n >= 32'sd1000) k = k + 4'd1;
      if (n >= 32'sd10000) k = k + 4'd1;
      if (n >= 32'sd100000) k = k + 4'd1;
      if (n >= 32'sd1000000) k = k + 4'd1;
      if (n >= 32'sd10000000) k = k + 4'd1;
      return k;
   endfunction

   function automatic logic [26:0] pow10(input logic [3:0] k);
      logic [26:0] p;
      case (k)
         4'd1: p = 27'd10;
         4'd2: p = 27'd100;
         4'd3: p = 27'd1000;
         4'd4: p = 27'd10000;
         4'd5: p = 27'd100000;
         4'd6: p = 27'd1000000;
         4'd7: p = 27'd10000000;
         4'd8: p = 27'd100000000;
         default: p = 27'd1;
      endcase
      return p;
   endfunction

endpackage

### hdl/dfam_div_unit.sv
// shared iterative unsigned divider: 64 by 32 bit, or a fast divide-by-ten mode
`timescale 1ns / 1ps

module dfam_div_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  dfam_pkg::dfam_div_req_type div_req,
   input  logic [63:0]                dividend,
   input  logic [31:0]                divisor,
   output logic [63:0]                quotient,
   output logic                       done
);

   logic [63:0] q_ff, q_in;
   logic [31:0] rem_ff, rem_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        fast_ff, fast_in;
   logic        done_ff, done_in;

   always_comb begin
      logic [4:0]  r5;
      logic [3:0]  r4;
      logic [7:0]  qb;
      logic [32:0] sh;
      logic [32:0] df;
      q_in = q_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      fast_in = fast_ff;
      done_in = 1'b0;
      r5 = '0;
      r4 = '0;
      qb = '0;
      sh = '0;
      df = '0;
      if (busy_ff) begin
         if (fast_ff) begin
            // eight bits a cycle, remainder stays below ten
            r4 = rem_ff[3:0];
            for (int i = 0; i < 8; i++) begin
               r5 = {r4, q_ff[63-i]};
               if (r5 >= dfam_pkg::TEN) begin
                  r4 = 4'(r5 - dfam_pkg::TEN);
                  qb[7-i] = 1'b1;
               end else begin
                  r4 = r5[3:0];
                  qb[7-i] = 1'b0;
               end
            end
            q_in = {q_ff[55:0], qb};
            rem_in = {28'd0, r4};
         end else begin
            sh = {rem_ff, q_ff[63]};
            df = sh - {1'b0, divisor};
            if (!df[32]) begin
               rem_in = df[31:0];
               q_in = {q_ff[62:0], 1'b1};
            end else begin
               rem_in = sh[31:0];
               q_in = {q_ff[62:0], 1'b0};
            end
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (div_req.start) begin
         q_in = dividend;
         rem_in = '0;
         fast_in = div_req.fast;
         cnt_in = div_req.fast ? dfam_pkg::DIV_FAST_CYCLES : dfam_pkg::DIV_SLOW_CYCLES;
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
         fast_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
         fast_ff <= fast_in;
      end
      q_ff <= q_in;
      rem_ff <= rem_in;
   end

   assign quotient = q_ff;
   assign done = done_ff;

endmodule

### hdl/decimal_float_add_mul_div_top.sv
// top level of the decimal float add, multiply and divide unit
`timescale 1ns / 1ps

// usage
// - req channel: one transaction carries an operation code in req_tuser and two
//   decimal floats (mantissa times ten to an exponent) in req_tdata
// - rsp channel: one transaction per request with the result float in rsp_tdata
//   and the divide-by-zero flag in rsp_tuser
// - one request at a time: req_tready is high only while the sequencer is idle
// - every divide goes through one shared iterative divider: either a general
//   long divide or a truncating divide by ten
// - add: one alignment step per exponent difference (up to nine) plus one
//   optional normalising step
// - multiply: one normalising step per surplus digit (up to ten)
// - divide: the long divide plus at most two normalising steps; zero divisor
//   and the unused code go straight to the result
// - the result sits in an output register; the next request is taken while it
//   waits, and a finished result waits in the sequencer while rsp_tready is low
// - reset (synchronous, active high) empties the output register and returns
//   the sequencer to idle

module decimal_float_add_mul_div_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,  // a_mant, a_exp, b_mant, b_exp
   input  logic [1:0]   req_tuser,  // req_type
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [63:0]  rsp_tdata,  // res_mant, res_exp
   output logic [0:0]   rsp_tuser   // div_by_zero
);

   dfam_pkg::dfam_state_type state_ff, state_in;

   // latched request
   logic [1:0]         op_ff, op_in;
   logic signed [31:0] am_ff, am_in, ae_ff, ae_in, bm_ff, bm_in, be_ff, be_in;

   // working value: sign and magnitude of the mantissa, plus exponent
   logic [63:0] mag_ff, mag_in;
   logic        neg_ff, neg_in;
   logic [31:0] exp_ff, exp_in;
   logic        dz_ff, dz_in;
   logic signed [31:0] hi_ff, hi_in;  // addend that keeps its exponent
   logic [3:0]  steps_ff, steps_in;   // alignment divides still to do

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_mant_ff, rsp_mant_in, rsp_exp_ff, rsp_exp_in;
   logic        rsp_dz_ff, rsp_dz_in;

   dfam_pkg::dfam_div_req_type div_req;
   logic [31:0] div_divisor;
   logic [63:0] div_quot;
   logic        div_done;

   dfam_div_unit u_div (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .dividend (mag_ff),
      .divisor  (div_divisor),
      .quotient (div_quot),
      .done     (div_done)
   );

   // divisor magnitude, -2^31 maps to 2^31
   assign div_divisor = bm_ff[31] ? 32'(-bm_ff) : bm_ff;

   always_comb begin
      logic signed [32:0] diff;
      logic signed [63:0] prod;
      logic [3:0]         k;
      logic signed [33:0] lo_s;
      logic signed [33:0] sum;
      state_in = state_ff;
      op_in = op_ff;
      am_in = am_ff;
      ae_in = ae_ff;
      bm_in = bm_ff;
      be_in = be_ff;
      mag_in = mag_ff;
      neg_in = neg_ff;
      exp_in = exp_ff;
      dz_in = dz_ff;
      hi_in = hi_ff;
      steps_in = steps_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_mant_in = rsp_mant_ff;
      rsp_exp_in = rsp_exp_ff;
      rsp_dz_in = rsp_dz_ff;
      req_tready = 1'b0;
      div_req = '0;
      diff = '0;
      prod = '0;
      k = dfam_pkg::scale_digits(bm_ff);
      lo_s = '0;
      sum = '0;

      case (state_ff)
         dfam_pkg::ST_IDLE: begin
            req_tready = !reset;
            if (req_tvalid) begin
               op_in = req_tuser;
               am_in = req_tdata[31:0];
               ae_in = req_tdata[63:32];
               bm_in = req_tdata[95:64];
               be_in = req_tdata[127:96];
               state_in = dfam_pkg::ST_DECODE;
            end
         end
         dfam_pkg::ST_DECODE: begin
            neg_in = 1'b0;
            mag_in = '0;
            exp_in = '0;
            dz_in = 1'b0;
            case (op_ff)
               dfam_pkg::OP_ADD: begin
                  // smaller exponent operand gets aligned
                  if (ae_ff < be_ff) begin
                     diff = 33'(be_ff) - 33'(ae_ff);
                     lo_s = 34'(am_ff);
                     hi_in = bm_ff;
                     exp_in = be_ff;
                  end else begin
                     diff = 33'(ae_ff) - 33'(be_ff);
                     lo_s = 34'(bm_ff);
                     hi_in = am_ff;
                     exp_in = ae_ff;
                  end
                  neg_in = lo_s[33];
                  mag_in = 64'(lo_s[33] ? -lo_s : lo_s);
                  if (diff >= 33'sd10) begin
                     mag_in = '0;
                     steps_in = '0;
                  end else begin
                     steps_in = diff[3:0];
                  end
                  state_in = dfam_pkg::ST_ALIGN;
               end
               dfam_pkg::OP_MUL: state_in = dfam_pkg::ST_MUL;
               dfam_pkg::OP_DIV: begin
                  if (bm_ff == 32'sd0) begin
                     dz_in = 1'b1;
                     state_in = dfam_pkg::ST_FIN;
                  end else begin
                     state_in = dfam_pkg::ST_SCALE;
                  end
               end
               default: state_in = dfam_pkg::ST_FIN;
            endcase
         end
         dfam_pkg::ST_MUL: begin
            prod = 64'(am_ff) * 64'(bm_ff);
            neg_in = prod[63];
            mag_in = prod[63] ? 64'(-prod) : 64'(prod);
            exp_in = ae_ff + be_ff;
            state_in = dfam_pkg::ST_NORM;
         end
         dfam_pkg::ST_SCALE: begin
            // dividend scaled by ten to scale_digits of the divisor: its digit count capped at 8, 1 below ten
            prod = 64'(am_ff) * 64'($signed({5'd0, dfam_pkg::pow10(k)}));
            neg_in = prod[63] ^ bm_ff[31];
            mag_in = prod[63] ? 64'(-prod) : 64'(prod);
            exp_in = ae_ff - {28'd0, k} - be_ff;
            state_in = dfam_pkg::ST_DIV;
         end
         dfam_pkg::ST_DIV: begin
            div_req.start = 1'b1;
            div_req.fast = 1'b0;
            state_in = dfam_pkg::ST_DWAIT;
         end
         dfam_pkg::ST_DWAIT: begin
            if (div_done) begin
               mag_in = div_quot;
               state_in = dfam_pkg::ST_NORM;
            end
         end
         dfam_pkg::ST_ALIGN: begin
            if (steps_ff == 4'd0) begin
               lo_s = neg_ff ? -34'(mag_ff[32:0]) : 34'(mag_ff[32:0]);
               sum = 34'(hi_ff) + lo_s;
               neg_in = sum[33];
               mag_in = 64'(sum[33] ? -sum : sum);
               state_in = dfam_pkg::ST_NORM;
            end else begin
               div_req.start = 1'b1;
               div_req.fast = 1'b1;
               state_in = dfam_pkg::ST_AWAIT;
            end
         end
         dfam_pkg::ST_AWAIT: begin
            if (div_done) begin
               mag_in = div_quot;
               steps_in = steps_ff - 4'd1;
               state_in = dfam_pkg::ST_ALIGN;
            end
         end
         dfam_pkg::ST_NORM: begin
            if (mag_ff <= dfam_pkg::MANT_LIMIT) begin
               state_in = dfam_pkg::ST_FIN;
            end else begin
               div_req.start = 1'b1;
               div_req.fast = 1'b1;
               state_in = dfam_pkg::ST_NWAIT;
            end
         end
         dfam_pkg::ST_NWAIT: begin
            if (div_done) begin
               mag_in = div_quot;
               exp_in = exp_ff + 32'd1;
               state_in = dfam_pkg::ST_NORM;
            end
         end
         dfam_pkg::ST_FIN: begin
            // hand over once the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_mant_in = neg_ff ? -mag_ff[31:0] : mag_ff[31:0];
               rsp_exp_in = exp_ff;
               rsp_dz_in = dz_ff;
               state_in = dfam_pkg::ST_IDLE;
            end
         end
         default: state_in = dfam_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dfam_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff <= op_in;
      am_ff <= am_in;
      ae_ff <= ae_in;
      bm_ff <= bm_in;
      be_ff <= be_in;
      mag_ff <= mag_in;
      neg_ff <= neg_in;
      exp_ff <= exp_in;
      dz_ff <= dz_in;
      hi_ff <= hi_in;
      steps_ff <= steps_in;
      rsp_mant_ff <= rsp_mant_in;
      rsp_exp_ff <= rsp_exp_in;
      rsp_dz_ff <= rsp_dz_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {rsp_exp_ff, rsp_mant_ff};
   assign rsp_tuser = rsp_dz_ff;

   // normalisation never yields the most negative mantissa
   a_no_min_mant: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[31:0] != 32'h80000000)
      else $error("result mantissa out of range");

   // divide by zero carries an all-zero result
   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> rsp_tdata == 64'd0)
      else $error("divide by zero result not zero");

   // each normalising divide raises the exponent by one
   a_norm_exp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dfam_pkg::ST_NWAIT && div_done) |=> exp_ff == $past(exp_ff) + 32'd1)
      else $error("normalise exponent step wrong");

   // the divider only finishes while the sequencer waits for it
   a_done_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == dfam_pkg::ST_DWAIT || state_ff == dfam_pkg::ST_AWAIT
                    || state_ff == dfam_pkg::ST_NWAIT))
      else $error("divider done outside a wait state");

endmodule

### bench/tb_decimal_float_add_mul_div_top.sv
// self-checking testbench of the decimal float add, multiply and divide unit
`timescale 1ns / 1ps

module tb_decimal_float_add_mul_div_top;

   localparam int RANDOM_OPS = 1250;
   localparam int CYCLE_LIMIT = 1000000;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef struct {
      logic [1:0]         op;
      logic signed [31:0] am;
      logic signed [31:0] ae;
      logic signed [31:0] bm;
      logic signed [31:0] be;
   } dec_op_type;

   typedef struct {
      logic signed [31:0] mant;
      logic signed [31:0] expo;
      logic               dz;
   } dec_res_type;

   // directed row: operation plus optional typed-in result
   typedef struct {
      dec_op_type  op;
      bit          known;
      dec_res_type res;
   } dir_row_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [127:0] req_tdata;   // a_mant, a_exp, b_mant, b_exp
   logic [1:0]   req_tuser;   // req_type
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [63:0]  rsp_tdata;   // res_mant, res_exp
   logic [0:0]   rsp_tuser;   // div_by_zero

   dec_res_type pending_results[$];
   int          errors;
   int          cycles;

   decimal_float_add_mul_div_top dut (.*);

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // truncating divide of a 64-bit mantissa by ten until it fits 32 bits
   function automatic void fit_mantissa(inout logic signed [63:0] m,
                                        inout logic signed [31:0] e);
      while ((m < 0 ? -m : m) > 64'sd2147483647) begin
         m = m / 64'sd10;
         e = e + 32'sd1;
      end
   endfunction

   function automatic dec_res_type compute_result(dec_op_type t);
      dec_res_type r;
      logic signed [63:0] lo, hi, m, p;
      logic signed [31:0] e;
      longint diff;
      int k;
      r.mant = '0;
      r.expo = '0;
      r.dz = 1'b0;
      m = '0;
      e = '0;
      case (t.op)
         dfam_pkg::OP_ADD: begin
            if (t.ae < t.be) begin
               diff = longint'(t.be) - longint'(t.ae);
               lo = t.am;
               hi = t.bm;
               e = t.be;
            end else begin
               diff = longint'(t.ae) - longint'(t.be);
               lo = t.bm;
               hi = t.am;
               e = t.ae;
            end
            if (diff >= 10) lo = 0;
            else for (int i = 0; i < diff; i++) lo = lo / 64'sd10;
            m = lo + hi;
            if (m > 64'sd2147483647 || m < -64'sd2147483647) begin
               m = m / 64'sd10;
               e = e + 32'sd1;
            end
         end
         dfam_pkg::OP_MUL: begin
            m = 64'(t.am) * 64'(t.bm);
            e = t.ae + t.be;
            fit_mantissa(m, e);
         end
         dfam_pkg::OP_DIV: begin
            if (t.bm == 0) begin
               r.dz = 1'b1;
            end else begin
               k = 1;
               p = 10;
               while (k < 8 && 64'(t.bm) >= p) begin
                  k++;
                  p = p * 10;
               end
               m = (64'(t.am) * p) / 64'(t.bm);
               e = t.ae - 32'(k) - t.be;
               fit_mantissa(m, e);
            end
         end
         default: ;
      endcase
      r.mant = m[31:0];
      r.expo = e;
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycles);
      errors++;
   endtask

   // drive one transaction and wait for acceptance at a rising edge
   task automatic send_op(dec_op_type t);
      req_tdata <= {t.be, t.bm, t.ae, t.am};
      req_tuser <= t.op;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(compute_result(t));
   endtask

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 5))
         0: return 32'(signed'($urandom_range(0, 20)) - 10);
         1: return {1'b1, 31'h0};
         2: return 32'h7fffffff;
         3: return 32'(signed'($urandom_range(0, 2000000)) - 1000000);
         default: return $urandom;
      endcase
   endfunction

   function automatic dec_op_type random_op();
      dec_op_type t;
      int pick;
      pick = $urandom_range(0, 99);
      t.op = pick < 32 ? dfam_pkg::OP_ADD : pick < 64 ? dfam_pkg::OP_MUL :
             pick < 96 ? dfam_pkg::OP_DIV : OP_UNUSED;
      t.am = rand_word();
      t.bm = ($urandom_range(0, 19) == 0) ? 32'sd0 : rand_word();
      // mostly close exponents so add alignment is exercised in depth
      if ($urandom_range(0, 3) != 0) begin
         t.ae = rand_word();
         t.be = t.ae + 32'(signed'($urandom_range(0, 24)) - 12);
      end else begin
         t.ae = rand_word();
         t.be = rand_word();
      end
      return t;
   endfunction

   // receiver: stall pattern of its own, alternating busy and calm stretches
   always @(negedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else if ((cycles / 300) % 3 == 0) rsp_tready <= 1'b1;
      else rsp_tready <= ($urandom_range(0, 99) < 60);
   end

   // check each result transaction against the oldest expectation
   always @(posedge clock) begin
      dec_res_type w;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $display("unexpected result transaction at cycle %0d", cycles);
            errors++;
         end else begin
            w = pending_results.pop_front();
            if (rsp_tdata[31:0] !== w.mant) report_mismatch("res_mant", rsp_tdata[31:0], w.mant);
            if (rsp_tdata[63:32] !== w.expo) report_mismatch("res_exp", rsp_tdata[63:32], w.expo);
            if (rsp_tuser[0] !== w.dz) report_mismatch("div_by_zero", 32'(rsp_tuser), 32'(w.dz));
         end
      end
   end

   // cycle counter with timeout
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      dir_row_type rows[$];
      dir_row_type row;
      dec_res_type got;
      int burst;
      errors = 0;
      cycles = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = dfam_pkg::OP_ADD;

      // directed table: ops, mantissa and exponent extremes, special cases
      rows = '{
         '{'{dfam_pkg::OP_ADD, 32'sd0, 32'sd0, 32'sd0, 32'sd0}, 1, '{32'sd0, 32'sd0, 1'b0}},
         '{'{dfam_pkg::OP_ADD, 32'sd5, 32'sd0, 32'sd7, 32'sd0}, 1, '{32'sd12, 32'sd0, 1'b0}},
         '{'{dfam_pkg::OP_ADD, 32'sh7fffffff, 32'sd3, 32'sh7fffffff, 32'sd3}, 0, '{0, 0, 0}},
         '{'{dfam_pkg::OP_ADD, 32'sh80000000, 32'sd0, 32'sh80000000, 32'sd0}, 0, '{0, 0, 0}},
         '{'{dfam_pkg::OP_ADD, 32'sd123456, 32'sd0, 32'sd9, 32'sd12}, 1,
           '{32'sd9, 32'sd12, 1'b0}},
         '{'{dfam_pkg::OP_ADD, 32'sd123456, 32'sd0, 32'sd9, 32'sd3}, 0, '{0, 0, 0}},
         '{'{dfam_pkg::OP_ADD, 32'sd1, 32'sh80000000, 32'sd1, 32'sh7fffffff}, 0, '{0, 0, 0}},
         '{'{dfam_pkg::OP_MUL, 32'sd6, 32'sd2, 32'sd7, 32'sd3}, 1, '{32'sd42, 32'sd5, 1'b0}},
         '{'{dfam_pkg::OP_MUL, 32'sh80000000, 32'sd0, 32'sh80000000, 32'sd0}, 0, '{0, 0, 0}},
         '{'{dfam_pkg::OP_MUL, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sd1}, 0,
           '{0, 0, 0}},
         '{'{dfam_pkg::OP_MUL, -32'sd1, 32'sh80000000, 32'sh80000000, -32'sd1}, 0, '{0, 0, 0}},
         '{'{dfam_pkg::OP_DIV, 32'sd5, 32'sd9, 32'sd0, 32'sd4}, 1, '{32'sd0, 32'sd0, 1'b1}},
         '{'{dfam_pkg::OP_DIV, 32'sd10, 32'sd0, 32'sd5, 32'sd0}, 1, '{32'sd20, -32'sd1, 1'b0}},
         '{'{dfam_pkg::OP_DIV, 32'sh7fffffff, 32'sd0, 32'sd123456789, 32'sd0}, 0, '{0, 0, 0}},
         '{'{dfam_pkg::OP_DIV, 32'sh80000000, 32'sd0, -32'sd1, 32'sd0}, 0, '{0, 0, 0}},
         '{'{dfam_pkg::OP_DIV, 32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff}, 0,
           '{0, 0, 0}},
         '{'{dfam_pkg::OP_DIV, -32'sd7, 32'sd0, -32'sd3, 32'sd0}, 0, '{0, 0, 0}},
         '{'{OP_UNUSED, 32'sd99, 32'sd9, 32'sd0, 32'sd1}, 1, '{32'sd0, 32'sd0, 1'b0}},
         '{'{OP_UNUSED, -32'sd1, -32'sd1, -32'sd1, -32'sd1}, 1, '{32'sd0, 32'sd0, 1'b0}}
      };

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (rows[i]) begin
         row = rows[i];
         @(negedge clock);
         send_op(row.op);
         // typed-in rows also cross-check the predictor itself
         if (row.known) begin
            got = compute_result(row.op);
            if (got.mant !== row.res.mant || got.expo !== row.res.expo
                || got.dz !== row.res.dz) begin
               $display("table row %0d disagrees with prediction", i);
               errors++;
            end
            pending_results[$] = row.res;
         end
         @(negedge clock);
         req_tvalid <= 1'b0;
      end

      // random part: bursts of back-to-back transactions with random gaps
      for (int n = 0; n < RANDOM_OPS; ) begin
         burst = $urandom_range(1, 12);
         for (int b = 0; b < burst && n < RANDOM_OPS; b++, n++) begin
            @(negedge clock);
            send_op(random_op());
         end
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40)) @(negedge clock);
      end

      while (pending_results.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);

      if (errors == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

endmodule

### sim.f
hdl/dfam_pkg.sv
hdl/dfam_div_unit.sv
hdl/decimal_float_add_mul_div_top.sv
bench/tb_decimal_float_add_mul_div_top.sv
